@@ hdl/base64url_stream_encoder_assert.svh @@
// Assertion macros used by the checker file of the encoder.
`ifndef BASE64URL_STREAM_ENCODER_ASSERT_SVH
`define BASE64URL_STREAM_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64U_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("encoder check failed: same-cycle rule");

// The consequent must hold in the cycle after the antecedent.
`define B64U_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("encoder check failed: next-cycle rule");

`endif

@@ hdl/b64u_pkg.sv @@
// Types, codes and the character table of the base64url stream encoder.
`timescale 1ns / 1ps
`default_nettype none

package b64u_pkg;

	localparam int unsigned COUNT_W   = 17;
	localparam int unsigned CAP_W     = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [CAP_W-1:0]   CAP_RESET = 16'hFFFF;

	// Bytes already taken into the current three-byte group.
	typedef enum logic [1:0] {
		PH_0 = 2'd0,
		PH_1 = 2'd1,
		PH_2 = 2'd2
	} b64u_phase_t;

	// One queue entry: the one or two characters caused by a single byte.
	typedef struct packed {
		logic [5:0] six0;
		logic [5:0] six1;
		logic       two;
		logic       last;
		logic       too_long;
	} b64u_entry_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} b64u_qstat_t;

	// Six-bit code to its ASCII character in the URL-safe alphabet.
	function automatic logic [7:0] b64u_char(input logic [5:0] six);
		logic [7:0] v;
		logic [7:0] c;
		begin
			v = {2'b00, six};
			if (v < 8'd26) begin
				c = 8'h41 + v;
			end else if (v < 8'd52) begin
				c = 8'h61 + (v - 8'd26);
			end else if (v < 8'd62) begin
				c = 8'h30 + (v - 8'd52);
			end else if (v == 8'd62) begin
				c = 8'h2D;
			end else begin
				c = 8'h5F;
			end
			return c;
		end
	endfunction

endpackage

`default_nettype wire

@@ hdl/b64u_front.sv @@
// Front part: takes bytes, splits them into six-bit codes and queues them.
`timescale 1ns / 1ps
`default_nettype none

module b64u_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [b64u_pkg::CAP_W-1:0] cfg_wdata,
	input  wire logic                       byte_valid,
	output logic                            byte_ready,
	input  wire logic [7:0]                 data_byte,
	input  wire logic                       last_byte,
	input  wire b64u_pkg::b64u_qstat_t      qstat,
	output logic                            push,
	output b64u_pkg::b64u_entry_t           push_entry
);

	logic [b64u_pkg::CAP_W-1:0]   cap_q;
	b64u_pkg::b64u_phase_t        phase_q;
	b64u_pkg::b64u_phase_t        phase_d;
	logic [3:0]                   left_q;
	logic [3:0]                   left_d;
	logic [b64u_pkg::COUNT_W-1:0] cnt_q;
	logic [b64u_pkg::COUNT_W-1:0] cnt_d;
	logic [b64u_pkg::COUNT_W:0]   sum;
	logic [5:0]                   six0;
	logic [5:0]                   six1;
	logic                         two;

	assign byte_ready = ~qstat.full;
	assign push       = byte_valid & byte_ready;

	always_comb begin
		six1    = '0;
		two     = 1'b0;
		unique case (phase_q)
			b64u_pkg::PH_1: begin
				six0    = {left_q[1:0], data_byte[7:4]};
				left_d  = data_byte[3:0];
				phase_d = b64u_pkg::PH_2;
				if (last_byte) begin
					six1 = {data_byte[3:0], 2'b00};
					two  = 1'b1;
				end
			end
			b64u_pkg::PH_2: begin
				six0    = {left_q, data_byte[7:6]};
				six1    = data_byte[5:0];
				two     = 1'b1;
				left_d  = '0;
				phase_d = b64u_pkg::PH_0;
			end
			default: begin
				// Start of a group; the unreachable fourth code lands here too.
				six0    = data_byte[7:2];
				left_d  = {2'b00, data_byte[1:0]};
				phase_d = b64u_pkg::PH_1;
				if (last_byte) begin
					six1 = {data_byte[1:0], 4'b0000};
					two  = 1'b1;
				end
			end
		endcase

		sum = {1'b0, cnt_q} + (two ? (b64u_pkg::COUNT_W+1)'(2) : (b64u_pkg::COUNT_W+1)'(1));
		if (sum > {1'b0, b64u_pkg::COUNT_MAX}) begin
			cnt_d = b64u_pkg::COUNT_MAX;
		end else begin
			cnt_d = sum[b64u_pkg::COUNT_W-1:0];
		end

		push_entry.six0     = six0;
		push_entry.six1     = six1;
		push_entry.two      = two;
		push_entry.last     = last_byte;
		// Characters plus the terminator exceed capacity when count >= capacity.
		push_entry.too_long = last_byte &
			(sum >= {{(b64u_pkg::COUNT_W+1-b64u_pkg::CAP_W){1'b0}}, cap_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= b64u_pkg::CAP_RESET;
			phase_q <= b64u_pkg::PH_0;
			left_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (push) begin
				if (last_byte) begin
					phase_q <= b64u_pkg::PH_0;
					left_q  <= '0;
					cnt_q   <= '0;
				end else begin
					phase_q <= phase_d;
					left_q  <= left_d;
					cnt_q   <= cnt_d;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/b64u_queue.sv @@
// Short queue of classified entries between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module b64u_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire b64u_pkg::b64u_entry_t push_entry,
	input  wire logic                  pop,
	output b64u_pkg::b64u_entry_t      head,
	output b64u_pkg::b64u_qstat_t      qstat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	b64u_pkg::b64u_entry_t slots_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;

	assign head        = slots_q[rptr_q];
	assign qstat.full  = (count_q == CNT_FULL);
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/b64u_back.sv @@
// Back part: turns queued entries into characters, one per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none

module b64u_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire b64u_pkg::b64u_entry_t head,
	input  wire b64u_pkg::b64u_qstat_t qstat,
	output logic                       pop,
	output logic                       char_valid,
	input  wire logic                  char_ready,
	output logic [7:0]                 out_char,
	output logic                       last_char,
	output logic                       too_long
);

	logic       sel_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       long_q;
	logic       load;
	logic       final_char;
	logic [5:0] six;

	assign char_valid = valid_q;
	assign out_char   = char_q;
	assign last_char  = last_q;
	assign too_long   = long_q;

	always_comb begin
		load       = ~qstat.empty & (~valid_q | char_ready);
		final_char = ~head.two | sel_q;
		six        = sel_q ? head.six1 : head.six0;
		pop        = load & final_char;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= b64u_pkg::b64u_char(six);
			last_q <= head.last & final_char;
			long_q <= head.too_long & final_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= ~final_char;
			end else if (char_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/base64url_stream_encoder.sv @@
// Top level of the unpadded URL-safe base64 stream encoder.
// Usage:
// Bytes enter on the byte channel (byte_valid/byte_ready, data_byte, last_byte),
// with last_byte set on the final byte of a message. Characters leave on the
// char channel (char_valid/char_ready, out_char, last_char, too_long). Every
// byte yields one or two characters; the final byte flushes a partial group
// as one extra character, and no padding is ever added. The final character
// of a message carries last_char, and too_long when the character count plus
// a terminating zero is greater than the capacity register.
// The user must write the capacity through cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce it. The capacity resets to 65535.
// A byte is written into the queue, and the back then loads its first character
// into the output register; a second character follows the first.
// The output register moves one character per cycle while char_ready is high
// and the queue is not empty.
// A queue of QUEUE_DEPTH entries separates byte intake from character output,
// so the front keeps taking bytes while the receiver stalls until the queue
// fills; then byte_ready drops. Reset clears the group state, the queue and
// the output register, and the first byte may be taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module base64url_stream_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             char_valid,
	input  wire logic        char_ready,
	output logic [7:0]       out_char,
	output logic             last_char,
	output logic             too_long
);

	// Queue handshake between the two halves.
	logic                  push;
	logic                  pop;
	b64u_pkg::b64u_entry_t push_entry;
	b64u_pkg::b64u_entry_t head;
	b64u_pkg::b64u_qstat_t qstat;

	// The front holds the group phase, the leftover bits and the character
	// count, and decides per byte which codes it yields and the final flags.
	b64u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	b64u_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// The back walks each entry one character at a time into its output
	// register and releases the entry with its final character.
	b64u_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.out_char   (out_char),
		.last_char  (last_char),
		.too_long   (too_long)
	);

endmodule

`default_nettype wire

@@ hdl/base64url_stream_encoder_checker.sv @@
// Port-level checker of the encoder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "base64url_stream_encoder_assert.svh"

module base64url_stream_encoder_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       char_valid,
	input wire logic       char_ready,
	input wire logic [7:0] out_char,
	input wire logic       last_char,
	input wire logic       too_long
);

	// A stalled character holds its value and flags.
	`B64U_ASSERT_NEXT(a_char_hold, char_valid && !char_ready, char_valid && $stable(out_char) && $stable(last_char) && $stable(too_long))

	// The overflow flag only ever rides on the final character of a message.
	`B64U_ASSERT_SAME(a_long_on_last, char_valid && too_long, last_char)

	// Every character comes from the URL-safe alphabet.
	`B64U_ASSERT_SAME(a_alphabet, char_valid, (out_char >= 8'h41 && out_char <= 8'h5A) || (out_char >= 8'h61 && out_char <= 8'h7A) || (out_char >= 8'h30 && out_char <= 8'h39) || out_char == 8'h2D || out_char == 8'h5F)

endmodule

bind base64url_stream_encoder base64url_stream_encoder_checker u_checker (.*);

`default_nettype wire
